// File: design/csa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and codes for the contiguous slot allocator: request and
// response payloads, operation and status codes, and the controller interface.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int OP_W     = 2;
  localparam int LEN_W    = 11;
  localparam int TK_W     = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPACT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COMPACTED = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [LEN_W-1:0] run_length;
    logic [TK_W-1:0]  ticket_to_free;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TK_W-1:0]     ticket;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_ZERO,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic scan_en;
    logic fill_en;
    logic zero_en;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic skip;
    logic found;
    logic scan_done;
    logic compact;
    logic fill_last;
    logic zero_done;
  } sts_t;

endpackage

// File: design/csa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_ctrl
// Sequencer for the slot allocator: clearing pass, scan, run fill, tail
// zeroing and response phases.
// ----------------------------------------------------------------------------
module csa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  csa_pkg::sts_t sts,
  output csa_pkg::cmd_t cmd,
  output logic          busy
);

  csa_pkg::state_t state_r;
  csa_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csa_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      csa_pkg::S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_nxt = csa_pkg::S_IDLE;
        end
      end
      csa_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = csa_pkg::S_SCAN;
        end
      end
      csa_pkg::S_SCAN: begin
        // Requests that are answered without touching the store leave at once.
        if (sts.skip) begin
          state_nxt = csa_pkg::S_RESP;
        end else begin
          cmd.scan_en = 1'b1;
          if (sts.found) begin
            state_nxt = csa_pkg::S_FILL;
          end else if (sts.scan_done) begin
            state_nxt = sts.compact ? csa_pkg::S_ZERO : csa_pkg::S_RESP;
          end
        end
      end
      csa_pkg::S_FILL: begin
        cmd.fill_en = 1'b1;
        if (sts.fill_last) begin
          state_nxt = csa_pkg::S_RESP;
        end
      end
      csa_pkg::S_ZERO: begin
        cmd.zero_en = 1'b1;
        if (sts.zero_done) begin
          state_nxt = csa_pkg::S_RESP;
        end
      end
      csa_pkg::S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = csa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = csa_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != csa_pkg::S_IDLE);

endmodule

// File: design/csa_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_dpath
// Slot owner memory, scan pipeline, pointers, ticket counter, configuration
// register and response register of the slot allocator.
// ----------------------------------------------------------------------------
module csa_dpath #(
  parameter int SLOT_COUNT  = 1024,
  parameter int TICKET_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  csa_pkg::cmd_t             cmd,
  input  csa_pkg::req_t             req,
  input  logic                      cfg_we,
  input  logic [csa_pkg::CFG_W-1:0] cfg_data,
  output csa_pkg::sts_t             sts,
  output logic                      out_strobe,
  output csa_pkg::rsp_t             out_rsp
);

  localparam int IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  logic [TICKET_BITS-1:0] mem [SLOT_COUNT];

  logic [csa_pkg::CFG_W-1:0] cfg_slots_r;
  logic [TICKET_BITS:0]      next_ticket_r;
  csa_pkg::req_t             req_r;

  logic [CNT_W-1:0]          rd_cnt_r;
  logic                      pipe_vld_r;
  logic [IW-1:0]             pipe_idx_r;
  logic [TICKET_BITS-1:0]    rd_data_r;
  logic [CNT_W-1:0]          w_cnt_r;
  logic [CNT_W-1:0]          run_r;
  logic [IW-1:0]             start_r;
  logic [csa_pkg::LEN_W-1:0] rem_r;
  logic                      found_r;
  logic                      hit_r;
  logic                      out_strobe_r;
  csa_pkg::rsp_t             rsp_r;

  logic [CNT_W-1:0]       managed;
  logic                   rd_more;
  logic                   proc;
  logic                   is_alloc;
  logic                   is_release;
  logic                   is_compact;
  logic                   slot_free;
  logic                   tk_match;
  logic                   found;
  logic [IW-1:0]          run_start;
  logic                   we;
  logic [IW-1:0]          wa;
  logic [TICKET_BITS-1:0] wd;

  // Managed count is the register clipped to the physical slot count.
  assign managed = (32'(cfg_slots_r) > 32'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT)
                                                        : CNT_W'(cfg_slots_r);

  assign is_alloc   = (req_r.op == csa_pkg::OP_ALLOC);
  assign is_release = (req_r.op == csa_pkg::OP_RELEASE);
  assign is_compact = (req_r.op == csa_pkg::OP_COMPACT);

  assign rd_more   = (rd_cnt_r < managed);
  assign proc      = cmd.scan_en && pipe_vld_r;
  assign slot_free = (rd_data_r == '0);
  assign tk_match  = (32'(rd_data_r) == 32'(req_r.ticket_to_free));
  assign run_start = (run_r == '0) ? pipe_idx_r : start_r;
  assign found     = proc && is_alloc && slot_free
                     && ((32'(run_r) + 32'd1) == 32'(req_r.run_length));

  always_comb begin
    sts            = '0;
    sts.clear_last = (w_cnt_r == CNT_W'(SLOT_COUNT - 1));
    sts.skip       = (req_r.op != csa_pkg::OP_ALLOC && req_r.op != csa_pkg::OP_RELEASE
                      && req_r.op != csa_pkg::OP_COMPACT)
                     || (is_alloc && ((req_r.run_length == '0)
                                      || (32'(req_r.run_length) > 32'(managed))
                                      || next_ticket_r[TICKET_BITS]))
                     || (is_release && (req_r.ticket_to_free == '0));
    sts.found      = found;
    sts.scan_done  = !rd_more && !pipe_vld_r;
    sts.compact    = is_compact;
    sts.fill_last  = (rem_r == '0);
    sts.zero_done  = (w_cnt_r >= managed);
  end

  // Single write port.
  always_comb begin
    we = 1'b0;
    wa = w_cnt_r[IW-1:0];
    wd = '0;
    if (cmd.clear_en) begin
      we = 1'b1;
    end else if (cmd.fill_en) begin
      we = 1'b1;
      wd = next_ticket_r[TICKET_BITS-1:0];
    end else if (cmd.zero_en) begin
      we = (w_cnt_r < managed);
    end else if (proc && is_release && tk_match) begin
      we = 1'b1;
      wa = pipe_idx_r;
    end else if (proc && is_compact && !slot_free) begin
      // The write pointer never passes the slot in hand, so no unread slot is lost.
      we = 1'b1;
      wd = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r  <= mem[rd_cnt_r[IW-1:0]];
    pipe_idx_r <= rd_cnt_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
    end
    if (cmd.load) begin
      run_r <= '0;
    end else if (proc && is_alloc) begin
      run_r <= slot_free ? run_r + CNT_W'(1) : '0;
    end
    if (proc && is_alloc && slot_free && (run_r == '0)) begin
      start_r <= pipe_idx_r;
    end
    if (found) begin
      rem_r <= req_r.run_length - csa_pkg::LEN_W'(1);
    end else if (cmd.fill_en) begin
      rem_r <= rem_r - csa_pkg::LEN_W'(1);
    end
    if (cmd.respond) begin
      rsp_r.status <= !is_alloc && !is_release && !is_compact ? csa_pkg::ST_NO_ROOM :
                      is_compact ? csa_pkg::ST_COMPACTED :
                      is_release ? (hit_r ? csa_pkg::ST_RELEASED : csa_pkg::ST_NOT_FOUND) :
                      (found_r ? csa_pkg::ST_ALLOCATED : csa_pkg::ST_NO_ROOM);
      rsp_r.ticket <= (is_alloc && found_r) ? csa_pkg::TK_W'(next_ticket_r[TICKET_BITS-1:0])
                                            : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_slots_r   <= csa_pkg::CFG_RESET;
      next_ticket_r <= (TICKET_BITS + 1)'(1);
      rd_cnt_r      <= '0;
      pipe_vld_r    <= 1'b0;
      w_cnt_r       <= '0;
      found_r       <= 1'b0;
      hit_r         <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_slots_r <= cfg_data;
      end
      if (cmd.load) begin
        rd_cnt_r   <= '0;
        pipe_vld_r <= 1'b0;
      end else if (cmd.scan_en) begin
        rd_cnt_r   <= rd_more ? rd_cnt_r + CNT_W'(1) : rd_cnt_r;
        pipe_vld_r <= rd_more;
      end
      if (cmd.load) begin
        w_cnt_r <= '0;
      end else if (found) begin
        w_cnt_r <= CNT_W'(run_start);
      end else if (cmd.clear_en || cmd.fill_en || (cmd.zero_en && (w_cnt_r < managed))) begin
        w_cnt_r <= w_cnt_r + CNT_W'(1);
      end else if (proc && is_compact && !slot_free) begin
        w_cnt_r <= w_cnt_r + CNT_W'(1);
      end
      if (cmd.load) begin
        found_r <= 1'b0;
        hit_r   <= 1'b0;
      end else begin
        if (found) begin
          found_r <= 1'b1;
        end
        if (proc && is_release && tk_match) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.respond && is_alloc && found_r) begin
        next_ticket_r <= next_ticket_r + (TICKET_BITS + 1)'(1);
      end
      out_strobe_r <= cmd.respond;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_rsp    = rsp_r;

endmodule

// File: design/contiguous_slot_allocator.sv
`timescale 1ns / 1ps
// The scan reads one slot a cycle through the single read port of the owner memory;
// invalid requests are answered without a scan.
// One request is in flight at a time; the response strobe is shown for one cycle.
// After reset the owner memory is cleared with busy high; configuration writes are
// taken at any time.
// ----------------------------------------------------------------------------
// contiguous_slot_allocator
// First-fit contiguous slot allocator with release by ticket and
// order-keeping compaction.
// ----------------------------------------------------------------------------
module contiguous_slot_allocator #(
  parameter int SLOT_COUNT  = 1024,
  parameter int TICKET_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  csa_pkg::req_t             in_req,
  output logic                      out_strobe,
  output csa_pkg::rsp_t             out_rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [csa_pkg::CFG_W-1:0] cfg_data
);

  csa_pkg::cmd_t cmd;
  csa_pkg::sts_t sts;
  logic          ctrl_busy;

  assign cfg_ready = 1'b1;
  assign busy      = ctrl_busy;

  csa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (ctrl_busy)
  );

  csa_dpath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .TICKET_BITS (TICKET_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .req        (in_req),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

endmodule

// File: design/csa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_checker
// Port-level checks for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module csa_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_strobe,
  input csa_pkg::rsp_t out_rsp
);

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A response is only shown once the block has gone idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("response strobe while busy");

  // One request gives one response, so strobes never come back to back.
  a_single_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two responses in consecutive cycles");

  a_ticket_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_rsp.status != csa_pkg::ST_ALLOCATED)) |-> (out_rsp.ticket == '0))
    else $error("nonzero ticket on a response other than allocated");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_rsp.status <= csa_pkg::ST_COMPACTED))
    else $error("response status out of range");

endmodule

bind contiguous_slot_allocator csa_checker u_csa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);
